// ===== hw/rtl/hmup_pkg.sv =====
// Shared types and constants for the heightmap 2x midpoint upsampler.
// No dependencies; imported by the channel interfaces and every RTL module but hmup_ram.
package hmup_pkg;

   localparam int DEF_MAX_HALF_WIDTH = 256;
   localparam int DEF_SAMPLE_BITS    = 24;
   localparam int MAX_HALF_LENGTH    = 256;

   // size registers and the position counters
   localparam int CFG_BITS       = 9;
   localparam int COORD_BITS     = CFG_BITS + 1;
   localparam int CSR_INDEX_BITS = 1;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_HALF_WIDTH  = 1'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_HALF_LENGTH = 1'd1;

   localparam int QUEUE_DEPTH = 4;

   // result kinds in emission order; also the slot of each height in a queue entry
   typedef enum logic [1:0] {
      KIND_FOUR = 2'd0,
      KIND_VERT = 2'd1,
      KIND_HORZ = 2'd2,
      KIND_COPY = 2'd3
   } hmup_kind_type;

   localparam int NUM_KINDS = 4;

   typedef struct packed {
      logic [CFG_BITS-1:0] col;
      logic [CFG_BITS-1:0] row;
   } hmup_pos_type;

endpackage

// ===== hw/rtl/hmup_req_if.sv =====
// Input sample channel: valid/ready handshake carrying one parent height.
// Depends on hmup_pkg.
interface hmup_req_if import hmup_pkg::*; #(
   parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] height;

   modport source (output valid, output height, input ready);
   modport sink   (input valid, input height, output ready);
endinterface

// ===== hw/rtl/hmup_rsp_if.sv =====
// Result channel: valid/ready handshake carrying one child height and its coordinates.
// Depends on hmup_pkg.
interface hmup_rsp_if import hmup_pkg::*; #(
   parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
);
   logic                          valid;
   logic                          ready;
   logic [COORD_BITS-1:0]         out_x;
   logic [COORD_BITS-1:0]         out_y;
   logic signed [SAMPLE_BITS-1:0] out_height;
   logic                          last;

   modport source (output valid, output out_x, output out_y, output out_height,
                   output last, input ready);
   modport sink   (input valid, input out_x, input out_y, input out_height,
                   input last, output ready);
endinterface

// ===== hw/rtl/hmup_csr_if.sv =====
// Configuration write channel: valid/ready handshake carrying register index and data.
// Depends on hmup_pkg.
interface hmup_csr_if import hmup_pkg::*;;
   logic                      valid;
   logic                      ready;
   logic [CSR_INDEX_BITS-1:0] index;
   logic [CFG_BITS-1:0]       data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hw/rtl/hmup_ram.sv =====
// Generic single-write, single-read RAM with registered, read-first output.
// No dependencies.
module hmup_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== hw/rtl/hmup_front.sv =====
// Front end: size registers, raster position counters, line buffer and the means.
// Depends on hmup_pkg, hmup_req_if, hmup_csr_if and hmup_ram.
module hmup_front import hmup_pkg::*; #(
   parameter int MAX_HALF_WIDTH = DEF_MAX_HALF_WIDTH,
   parameter int SAMPLE_BITS    = DEF_SAMPLE_BITS
) (
   input  logic                                    clock,
   input  logic                                    reset,
   hmup_req_if.sink                                req,
   hmup_csr_if.sink                                csr,
   output logic                                    push_valid,
   input  logic                                    push_ready,
   output hmup_pos_type                            push_pos,
   output logic [NUM_KINDS-1:0][SAMPLE_BITS-1:0]   push_heights
);
   localparam int AW = $clog2(MAX_HALF_WIDTH + 1);

   logic [CFG_BITS-1:0] half_width_ff, half_length_ff;
   logic [CFG_BITS-1:0] col_ff, row_ff;
   logic [CFG_BITS-1:0] hw_eff, hl_eff;
   logic [AW-1:0]       buf_addr;

   logic                          s1_valid_ff;
   logic signed [SAMPLE_BITS-1:0] s1_h_ff;
   hmup_pos_type                  s1_pos_ff;
   logic signed [SAMPLE_BITS-1:0] left_ff, left_above_ff;
   logic signed [SAMPLE_BITS-1:0] above;
   logic signed [SAMPLE_BITS+1:0] sum_four;
   logic signed [SAMPLE_BITS:0]   sum_vert, sum_horz;
   logic signed [SAMPLE_BITS+1:0] mean_four;
   logic signed [SAMPLE_BITS:0]   mean_vert, mean_horz;
   logic                          accept, push;

   assign csr.ready = 1'b1;
   assign req.ready = !s1_valid_ff || push_ready;
   assign accept    = req.valid && req.ready;
   assign push      = s1_valid_ff && push_ready;

   // zero acts as one, oversize clamps to the maximum
   always_comb begin
      if (half_width_ff == '0) begin
         hw_eff = CFG_BITS'(1);
      end else if (int'(half_width_ff) > MAX_HALF_WIDTH) begin
         hw_eff = CFG_BITS'(MAX_HALF_WIDTH);
      end else begin
         hw_eff = half_width_ff;
      end
      if (half_length_ff == '0) begin
         hl_eff = CFG_BITS'(1);
      end else if (int'(half_length_ff) > MAX_HALF_LENGTH) begin
         hl_eff = CFG_BITS'(MAX_HALF_LENGTH);
      end else begin
         hl_eff = half_length_ff;
      end
      if (int'(col_ff) > MAX_HALF_WIDTH) begin
         buf_addr = AW'(MAX_HALF_WIDTH);
      end else begin
         buf_addr = AW'(col_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         half_width_ff  <= CFG_BITS'(1);
         half_length_ff <= CFG_BITS'(1);
      end else if (csr.valid) begin
         case (csr.index)
            CSR_HALF_WIDTH:  half_width_ff  <= csr.data;
            CSR_HALF_LENGTH: half_length_ff <= csr.data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (accept) begin
         if (col_ff >= hw_eff) begin
            col_ff <= '0;
            row_ff <= (row_ff >= hl_eff) ? '0 : row_ff + CFG_BITS'(1);
         end else begin
            col_ff <= col_ff + CFG_BITS'(1);
         end
      end
   end

   // read-first buffer: old entry comes out next cycle while the new sample lands
   hmup_ram #(
      .WIDTH (SAMPLE_BITS),
      .DEPTH (MAX_HALF_WIDTH + 1)
   ) u_row_buf (
      .clock   (clock),
      .wr_en   (accept),
      .wr_addr (buf_addr),
      .wr_data (req.height),
      .rd_en   (accept),
      .rd_addr (buf_addr),
      .rd_data (above)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         left_ff       <= '0;
         left_above_ff <= '0;
      end else begin
         if (accept) begin
            s1_valid_ff <= 1'b1;
         end else if (push) begin
            s1_valid_ff <= 1'b0;
         end
         if (push) begin
            left_ff       <= s1_h_ff;
            left_above_ff <= above;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_h_ff       <= req.height;
         s1_pos_ff.col <= col_ff;
         s1_pos_ff.row <= row_ff;
      end
   end

   always_comb begin
      sum_four  = (SAMPLE_BITS+2)'(s1_h_ff) + (SAMPLE_BITS+2)'(above)
                + (SAMPLE_BITS+2)'(left_ff) + (SAMPLE_BITS+2)'(left_above_ff);
      sum_vert  = (SAMPLE_BITS+1)'(s1_h_ff) + (SAMPLE_BITS+1)'(above);
      sum_horz  = (SAMPLE_BITS+1)'(s1_h_ff) + (SAMPLE_BITS+1)'(left_ff);
      mean_four = sum_four >>> 2;
      mean_vert = sum_vert >>> 1;
      mean_horz = sum_horz >>> 1;
   end

   assign push_valid             = s1_valid_ff;
   assign push_pos               = s1_pos_ff;
   assign push_heights[KIND_FOUR] = mean_four[SAMPLE_BITS-1:0];
   assign push_heights[KIND_VERT] = mean_vert[SAMPLE_BITS-1:0];
   assign push_heights[KIND_HORZ] = mean_horz[SAMPLE_BITS-1:0];
   assign push_heights[KIND_COPY] = s1_h_ff;
endmodule

// ===== hw/rtl/hmup_queue.sv =====
// Small register FIFO between front and back end.
// Depends on hmup_pkg.
module hmup_queue import hmup_pkg::*; #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  logic [WIDTH-1:0] push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output logic [WIDTH-1:0] pop_data
);
   localparam int PW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [QUEUE_DEPTH];
   logic [PW-1:0]    wr_ptr_ff, rd_ptr_ff;
   logic [CW-1:0]    count_ff;
   logic             do_push, do_pop;

   assign push_ready = count_ff != CW'(QUEUE_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_data   = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + CW'(1);
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end
endmodule

// ===== hw/rtl/hmup_back.sv =====
// Back end: walks the results of the head queue entry, one per cycle while the
// result port is not stalled, into an output register. Depends on hmup_pkg and hmup_rsp_if.
module hmup_back import hmup_pkg::*; #(
   parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  pop_valid,
   output logic                                  pop_ready,
   input  hmup_pos_type                          pop_pos,
   input  logic [NUM_KINDS-1:0][SAMPLE_BITS-1:0] pop_heights,
   hmup_rsp_if.source                            rsp
);
   hmup_kind_type kind_ff;
   hmup_kind_type cur;
   logic          has_four, has_vert, has_horz;
   logic          load;
   logic [COORD_BITS-1:0] x2, y2;

   logic                   out_valid_ff;
   logic [COORD_BITS-1:0]  out_x_ff, out_y_ff;
   logic [SAMPLE_BITS-1:0] out_height_ff;
   logic                   last_ff;

   assign has_vert = pop_pos.row != '0;
   assign has_horz = pop_pos.col != '0;
   assign has_four = has_vert && has_horz;

   // first result kind at or after the step pointer that this sample produces
   always_comb begin
      if (kind_ff == KIND_FOUR && has_four) begin
         cur = KIND_FOUR;
      end else if ((kind_ff == KIND_FOUR || kind_ff == KIND_VERT) && has_vert) begin
         cur = KIND_VERT;
      end else if (kind_ff != KIND_COPY && has_horz) begin
         cur = KIND_HORZ;
      end else begin
         cur = KIND_COPY;
      end
   end

   assign load      = pop_valid && (!out_valid_ff || rsp.ready);
   assign pop_ready = load && (cur == KIND_COPY);
   assign x2        = {pop_pos.col, 1'b0};
   assign y2        = {pop_pos.row, 1'b0};

   always_ff @(posedge clock) begin
      if (reset) begin
         kind_ff      <= KIND_FOUR;
         out_valid_ff <= 1'b0;
      end else begin
         if (load) begin
            out_valid_ff <= 1'b1;
            kind_ff      <= (cur == KIND_COPY) ? KIND_FOUR
                                               : hmup_kind_type'(2'(cur) + 2'd1);
         end else if (rsp.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         out_x_ff      <= (cur == KIND_FOUR || cur == KIND_HORZ) ? x2 - COORD_BITS'(1) : x2;
         out_y_ff      <= (cur == KIND_FOUR || cur == KIND_VERT) ? y2 - COORD_BITS'(1) : y2;
         out_height_ff <= pop_heights[cur];
         last_ff       <= cur == KIND_COPY;
      end
   end

   assign rsp.valid      = out_valid_ff;
   assign rsp.out_x      = out_x_ff;
   assign rsp.out_y      = out_y_ff;
   assign rsp.out_height = out_height_ff;
   assign rsp.last       = last_ff;
endmodule

// ===== hw/rtl/heightmap_2x_midpoint_upsampler_top.sv =====
// Top level of the heightmap 2x midpoint upsampler.
// Depends on hmup_pkg, the channel interfaces, hmup_front, hmup_queue and hmup_back.
//
// Parent samples enter in raster order (half_width+1 per row, half_length+1 rows,
// then the frame wraps). Each sample yields up to four child heights in the order
// four-corner mean, vertical mean, horizontal mean, copy, with last set on the copy;
// a sample in row 0 or column 0 yields two, the origin sample one. The result port
// issues one result per cycle while rsp_ch is ready. Samples are taken one per cycle
// while the four-entry queue ahead of the result stage has room; a sample passes
// the front-end stage register and the queue into the output register, which presents
// its first result. Means are floored (arithmetic shift of the exact sum).
// Size registers are meant to be written while the block is idle; the line buffer
// needs no clearing after reset.
module heightmap_2x_midpoint_upsampler_top import hmup_pkg::*; #(
   parameter int MAX_HALF_WIDTH = DEF_MAX_HALF_WIDTH,
   parameter int SAMPLE_BITS    = DEF_SAMPLE_BITS
) (
   input  logic       clock,
   input  logic       reset,
   hmup_req_if.sink   req_ch,
   hmup_csr_if.sink   csr_ch,
   hmup_rsp_if.source rsp_ch
);
   localparam int HW = NUM_KINDS * SAMPLE_BITS;
   localparam int EW = $bits(hmup_pos_type) + HW;

   logic                                  push_valid, push_ready;
   hmup_pos_type                          push_pos, pop_pos;
   logic [NUM_KINDS-1:0][SAMPLE_BITS-1:0] push_heights, pop_heights;
   logic                                  pop_valid, pop_ready;
   logic [EW-1:0]                         pop_data;

   hmup_front #(
      .MAX_HALF_WIDTH (MAX_HALF_WIDTH),
      .SAMPLE_BITS    (SAMPLE_BITS)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .req          (req_ch),
      .csr          (csr_ch),
      .push_valid   (push_valid),
      .push_ready   (push_ready),
      .push_pos     (push_pos),
      .push_heights (push_heights)
   );

   hmup_queue #(
      .WIDTH (EW)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  ({push_pos, push_heights}),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   assign pop_pos     = hmup_pos_type'(pop_data[EW-1:HW]);
   assign pop_heights = pop_data[HW-1:0];

   hmup_back #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .pop_valid   (pop_valid),
      .pop_ready   (pop_ready),
      .pop_pos     (pop_pos),
      .pop_heights (pop_heights),
      .rsp         (rsp_ch)
   );
endmodule
